/* sv/ultrasonic_vehicle_counter_defines.svh */
// Assertion macros shared by the counter RTL.
// Both sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef ULTRASONIC_VEHICLE_COUNTER_DEFINES_SVH
`define ULTRASONIC_VEHICLE_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("uvc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("uvc assertion failed");

`endif

/* sv/uvc_pkg.sv */
package uvc_pkg;

    localparam int CAL_SAMPLES_DEF = 10;
    localparam int CAL_IDX_W       = 4;
    localparam int CAL_SUM_W       = 20;

    localparam int ECHO_W          = 16;
    localparam int COUNT_W         = 16;
    localparam int TICK_W          = 12;
    localparam int GREEN_W         = 8;
    localparam int TICKS_PER_SEC   = 10;

    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 40;

    localparam logic [GREEN_W-1:0] GREEN_SECONDS_RST = 8'd10;
    localparam logic [ECHO_W-1:0]  TRIGGER_DROP_RST  = 16'd176;
    localparam logic [ECHO_W-1:0]  CLEAR_MARGIN_RST  = 16'd294;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_SECONDS = 2'd0,
        CFG_TRIGGER_DROP  = 2'd1,
        CFG_CLEAR_MARGIN  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic               report_valid;
        logic [COUNT_W-1:0] reported_count;
        logic [COUNT_W-1:0] running_count;
        logic               vehicle_armed;
        logic               baseline_ready;
    } t_result;

endpackage

/* sv/ultrasonic_vehicle_counter.sv */
// Ultrasonic vehicle counter. Each input item is one 100 ms tick: tuser carries the
// green flag and tdata the echo width in microseconds. The first CAL_SAMPLES green
// echoes are averaged into the empty-road baseline; after that a drop larger than
// trigger_drop arms detection and a return to at least baseline - clear_margin counts
// one vehicle. Every tick gives exactly one result item; on a green tick whose window
// timer has reached green_seconds * 10 ticks, tuser is set and the closed window's
// count is reported, then the count and timer restart. Throughput is one item per
// clock: all state is updated in the accept cycle by a single pass of compare/add
// logic plus one constant multiply for the baseline average, and the result enters
// a two-entry output stage (output register plus skid entry), so s_axis_tready
// drops only when both entries hold results the sink has not taken. Each result is
// registered in the output or skid register. Write configuration only while idle.
`include "ultrasonic_vehicle_counter_defines.svh"

module ultrasonic_vehicle_counter #(
    parameter int CAL_SAMPLES = uvc_pkg::CAL_SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [uvc_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [15:0] echo_us
    input  logic                             s_axis_tuser,   // [0] is_green

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] reported_count, [31:16] running_count, [32] vehicle_armed,
    // [33] baseline_ready, [39:34] zero
    output logic [uvc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tuser,   // [0] report_valid

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [uvc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [uvc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import uvc_pkg::*;

    // Exact division by CAL_SAMPLES for any CAL_SUM_W-bit sum: multiply by the
    // rounded-up reciprocal and shift.
    localparam int CalShift = CAL_SUM_W + $clog2(CAL_SAMPLES);
    localparam int MulW     = CAL_SUM_W + 2;
    localparam int ProdW    = CAL_SUM_W + MulW;
    localparam longint unsigned CalMulL =
        ((64'd1 << CalShift) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);
    localparam logic [MulW-1:0]      CalMul  = MulW'(CalMulL);
    localparam logic [CAL_IDX_W-1:0] CalLast = CAL_IDX_W'(CAL_SAMPLES - 1);
    localparam logic [CAL_IDX_W-1:0] CalN    = CAL_IDX_W'(CAL_SAMPLES);

    // configuration
    logic [GREEN_W-1:0] r_green_s;
    logic [ECHO_W-1:0]  r_trig;
    logic [ECHO_W-1:0]  r_margin;

    // block state
    logic [CAL_IDX_W-1:0] r_cal_index, n_cal_index;
    logic [CAL_SUM_W-1:0] r_cal_sum, n_cal_sum;
    logic [ECHO_W-1:0]    r_base, n_base;
    logic                 r_cal_done, n_cal_done;
    logic                 r_have_prev, n_have_prev;
    logic [ECHO_W-1:0]    r_prev, n_prev;
    logic                 r_armed, n_armed;
    logic [COUNT_W-1:0]   r_total, n_total;
    logic [TICK_W-1:0]    r_ticks, n_ticks;

    // output stage
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    t_result n_res;

    logic s_accept;
    logic m_pop;

    logic                 green;
    logic [ECHO_W-1:0]    echo;
    logic [CAL_SUM_W-1:0] cal_sum_inc;
    logic [ProdW-1:0]     cal_prod;
    logic [ECHO_W-1:0]    prev_eff;
    logic [ECHO_W-1:0]    drop;
    logic [ECHO_W-1:0]    threshold;
    logic                 arm_now;
    logic                 count_now;
    logic [TICK_W-1:0]    ticks_inc;
    logic [TICK_W-1:0]    win_limit;
    logic                 report;

    assign s_axis_tready = !r_skid_valid;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_pop         = r_out_valid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign green = s_axis_tuser;
    assign echo  = s_axis_tdata[ECHO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_s <= GREEN_SECONDS_RST;
            r_trig    <= TRIGGER_DROP_RST;
            r_margin  <= CLEAR_MARGIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GREEN_SECONDS: r_green_s <= i_cfg_data[GREEN_W-1:0];
                CFG_TRIGGER_DROP:  r_trig    <= i_cfg_data[ECHO_W-1:0];
                CFG_CLEAR_MARGIN:  r_margin  <= i_cfg_data[ECHO_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    always_comb begin
        cal_sum_inc = r_cal_sum + CAL_SUM_W'(echo);
        cal_prod    = ProdW'(cal_sum_inc) * ProdW'(CalMul);
        prev_eff  = r_have_prev ? r_prev : echo;
        drop      = (prev_eff > echo) ? (prev_eff - echo) : '0;
        threshold = (r_base > r_margin) ? (r_base - r_margin) : '0;
        arm_now   = r_armed || (drop > r_trig);
        count_now = arm_now && (echo >= threshold);
        ticks_inc = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;
        win_limit = TICK_W'(r_green_s) * TICK_W'(TICKS_PER_SEC);
        report    = green && (ticks_inc >= win_limit);

        n_cal_sum   = r_cal_sum;
        n_cal_index = r_cal_index;
        n_base      = r_base;
        n_cal_done  = r_cal_done;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_armed     = r_armed;
        n_total     = r_total;
        n_ticks     = ticks_inc;

        if (green && !r_cal_done) begin
            n_cal_sum   = cal_sum_inc;
            n_cal_index = r_cal_index + 1'b1;
            if (r_cal_index == CalLast) begin
                n_base     = ECHO_W'(cal_prod >> CalShift);
                n_cal_done = 1'b1;
            end
        end else if (green) begin
            n_have_prev = 1'b1;
            n_prev      = echo;
            n_armed     = arm_now && !count_now;
            if (count_now && (r_total != '1)) begin
                n_total = r_total + 1'b1;
            end
        end

        n_res.report_valid   = report;
        n_res.reported_count = report ? n_total : '0;
        if (report) begin
            n_total = '0;
            n_ticks = '0;
        end
        n_res.running_count  = n_total;
        n_res.vehicle_armed  = n_armed;
        n_res.baseline_ready = n_cal_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_index <= '0;
            r_cal_sum   <= '0;
            r_base      <= '0;
            r_cal_done  <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_armed     <= 1'b0;
            r_total     <= '0;
            r_ticks     <= '0;
        end else if (s_accept) begin
            r_cal_index <= n_cal_index;
            r_cal_sum   <= n_cal_sum;
            r_base      <= n_base;
            r_cal_done  <= n_cal_done;
            r_have_prev <= n_have_prev;
            r_prev      <= n_prev;
            r_armed     <= n_armed;
            r_total     <= n_total;
            r_ticks     <= n_ticks;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= s_accept;
            end
        end else if (s_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_pop) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (s_accept) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.report_valid;
    assign m_axis_tdata  = {6'b0, r_out.baseline_ready, r_out.vehicle_armed,
                            r_out.running_count, r_out.reported_count};

    `UVC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `UVC_ASSERT_NOW(a_armed_needs_cal, r_armed, r_cal_done)
    `UVC_ASSERT_NOW(a_cal_index_range, !r_cal_done, r_cal_index < CalN)
    `UVC_ASSERT_NEXT(a_report_restarts, s_accept && report, (r_total == '0) && (r_ticks == '0))
    `UVC_ASSERT_NEXT(a_state_holds, !s_accept, $stable(r_total) && $stable(r_ticks) && $stable(r_armed))

endmodule
